FILE: rtl/core/voxel_face_mesher_with_ao_defines.svh
// ------------------------------------------------------------------------
// Assertion macros used by the back part of the voxel mesher RTL.
// ------------------------------------------------------------------------
`ifndef VOXEL_FACE_MESHER_WITH_AO_DEFINES_SVH
`define VOXEL_FACE_MESHER_WITH_AO_DEFINES_SVH

// Clocked assertion, disabled while reset is held.
`define VFM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define VFM_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: rtl/core/vfm_pkg.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// vfm_pkg
// Types, constants and neighbor lookup helpers of the voxel face mesher.
// ------------------------------------------------------------------------
package vfm_pkg;

  localparam int unsigned NUM_FACES = 6;
  localparam int unsigned TEX_W     = 10;
  localparam int unsigned QUAD_W    = 18;
  localparam int unsigned COORD_W   = 5;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned MASK_W    = 27;
  localparam int unsigned Q_DEPTH   = 4;
  localparam int unsigned Q_AW      = 2;

  localparam int unsigned POS_Y_SHIFT = 6;
  localparam int unsigned POS_Z_SHIFT = 12;
  localparam int unsigned VERT_SHIFT  = 18;
  localparam int unsigned AO_SHIFT    = 20;
  localparam int unsigned TEX_SHIFT   = 22;
  localparam logic [1:0]  AO_MAX      = 2'd3;

  // Corner offsets per face and vertex: bit 0 is x, bit 1 is y, bit 2 is z.
  localparam logic [2:0] CORNER_OFS [NUM_FACES][4] = '{
    '{3'b010, 3'b000, 3'b100, 3'b110},
    '{3'b001, 3'b011, 3'b111, 3'b101},
    '{3'b000, 3'b001, 3'b101, 3'b100},
    '{3'b011, 3'b010, 3'b110, 3'b111},
    '{3'b010, 3'b011, 3'b001, 3'b000},
    '{3'b100, 3'b101, 3'b111, 3'b110}
  };

  typedef struct packed {
    logic [COORD_W-1:0]           x;
    logic [COORD_W-1:0]           y;
    logic [COORD_W-1:0]           z;
    logic [NUM_FACES-1:0]         faces;
    logic [MASK_W-1:0]            clear;
    logic [NUM_FACES*TEX_W-1:0]   tex;
    logic [QUAD_W-1:0]            base;
  } vfm_entry_t;

  function automatic logic [2:0] corner_ofs(logic [2:0] f, logic [1:0] vert);
    logic [2:0] c;
    c = 3'b000;
    for (int i = 0; i < NUM_FACES; i++) begin
      if (f == 3'(i)) begin
        c = CORNER_OFS[i][vert];
      end
    end
    return c;
  endfunction

  // Bit of the neighbor mask for the layer outside face f, stepped along the
  // two in-plane axes toward the corner of vertex vert where requested.
  function automatic logic [4:0] nb_index(logic [2:0] f, logic [1:0] vert,
                                          logic use_v, logic use_w);
    int         d [3];
    int         u;
    int         v;
    int         w;
    logic [2:0] c;
    d[0] = 0;
    d[1] = 0;
    d[2] = 0;
    u = int'(f[2:1]);
    if (u > 2) begin
      u = 2;
    end
    v = (u == 2) ? 0 : u + 1;
    w = (u == 0) ? 2 : u - 1;
    c = corner_ofs(f, vert);
    d[u] = f[0] ? 1 : -1;
    if (use_v) begin
      d[v] = d[v] + (c[v] ? 1 : -1);
    end
    if (use_w) begin
      d[w] = d[w] + (c[w] ? 1 : -1);
    end
    return 5'((d[0] + 1) * 9 + (d[1] + 1) * 3 + (d[2] + 1));
  endfunction

endpackage

FILE: rtl/core/vfm_front.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// vfm_front
// Accepts voxels, finds the visible faces and numbers their quads.
// ------------------------------------------------------------------------
module vfm_front import vfm_pkg::*; #(
  parameter int unsigned CHUNK_SIZE = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       chunk_start_i,
  input  logic [COORD_W-1:0]         block_x_i,
  input  logic [COORD_W-1:0]         block_y_i,
  input  logic [COORD_W-1:0]         block_z_i,
  input  logic                       block_solid_i,
  input  logic [MASK_W-1:0]          neighbour_clear_i,
  input  logic [NUM_FACES*TEX_W-1:0] face_textures_i,
  input  logic                       q_ready_i,
  output logic                       q_push_o,
  output vfm_entry_t                 q_entry_o
);

  localparam logic [POS_W-1:0] LIMIT = POS_W'(CHUNK_SIZE);

  logic [QUAD_W-1:0]    quad_q, quad_d;
  logic [QUAD_W-1:0]    base;
  logic [NUM_FACES-1:0] faces;
  logic [2:0]           n_faces;
  logic                 in_chunk;
  logic                 take;

  assign in_chunk = ({1'b0, block_x_i} < LIMIT) && ({1'b0, block_y_i} < LIMIT) &&
                    ({1'b0, block_z_i} < LIMIT);

  always_comb begin
    n_faces = 3'd0;
    for (int f = 0; f < NUM_FACES; f++) begin
      faces[f] = block_solid_i && in_chunk &&
                 neighbour_clear_i[nb_index(3'(f), 2'd0, 1'b0, 1'b0)];
      n_faces  = n_faces + {2'b00, faces[f]};
    end
  end

  assign in_ready_o = q_ready_i;
  assign take       = in_valid_i && q_ready_i;
  assign base       = chunk_start_i ? '0 : quad_q;
  assign quad_d     = take ? base + QUAD_W'(n_faces) : quad_q;

  // A hidden or air voxel adds no quads to the counter and never enters the queue.
  assign q_push_o        = take && (faces != '0);
  assign q_entry_o.x     = block_x_i;
  assign q_entry_o.y     = block_y_i;
  assign q_entry_o.z     = block_z_i;
  assign q_entry_o.faces = faces;
  assign q_entry_o.clear = neighbour_clear_i;
  assign q_entry_o.tex   = face_textures_i;
  assign q_entry_o.base  = base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_q <= '0;
    end else begin
      quad_q <= quad_d;
    end
  end

endmodule

FILE: rtl/core/vfm_fifo.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// vfm_fifo
// Short queue of classified voxels between the front and back parts.
// ------------------------------------------------------------------------
module vfm_fifo import vfm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  vfm_entry_t push_entry_i,
  output logic       ready_o,
  input  logic       pop_i,
  output logic       valid_o,
  output vfm_entry_t head_o
);

  vfm_entry_t      mem_q [Q_DEPTH];
  logic [Q_AW:0]   wr_q, wr_d;
  logic [Q_AW:0]   rd_q, rd_d;
  logic            full;
  logic            empty;

  assign empty   = (wr_q == rd_q);
  assign full    = (wr_q[Q_AW] != rd_q[Q_AW]) && (wr_q[Q_AW-1:0] == rd_q[Q_AW-1:0]);
  assign ready_o = !full;
  assign valid_o = !empty;
  assign head_o  = mem_q[rd_q[Q_AW-1:0]];

  assign wr_d = (push_i && !full) ? wr_q + 1'b1 : wr_q;
  assign rd_d = (pop_i && !empty) ? rd_q + 1'b1 : rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full) begin
      mem_q[wr_q[Q_AW-1:0]] <= push_entry_i;
    end
  end

endmodule

FILE: rtl/core/vfm_back.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// vfm_back
// Walks the visible faces of one voxel and emits four vertex words each.
// ------------------------------------------------------------------------
`include "voxel_face_mesher_with_ao_defines.svh"

module vfm_back import vfm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  vfm_entry_t        q_head_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [31:0]       vertex_word_o,
  output logic [QUAD_W-1:0] quad_index_o,
  output logic              last_o
);

  logic                 busy_q, busy_d;
  logic [NUM_FACES-1:0] rem_q, rem_d;
  logic [1:0]           vert_q, vert_d;
  logic [QUAD_W-1:0]    quad_q, quad_d;
  vfm_entry_t           cur_q;
  logic                 ov_q, ov_d;
  logic [31:0]          word_q;
  logic [QUAD_W-1:0]    qidx_q;
  logic                 last_q;

  logic [NUM_FACES-1:0] low;
  logic [2:0]           face;
  logic                 gen_en;
  logic                 last_vert;
  logic                 load;
  logic [2:0]           cofs;
  logic                 opa, opb, opc;
  logic [1:0]           ao;
  logic [TEX_W-1:0]     tex;
  logic [POS_W-1:0]     px, py, pz;
  logic [31:0]          word;

  assign low = rem_q & NUM_FACES'(~rem_q + 1'b1);

  always_comb begin
    face = 3'd0;
    tex  = '0;
    for (int f = NUM_FACES - 1; f >= 0; f--) begin
      if (low[f]) begin
        face = 3'(f);
      end
    end
    for (int f = 0; f < NUM_FACES; f++) begin
      if (face == 3'(f)) begin
        tex = cur_q.tex[f*TEX_W +: TEX_W];
      end
    end
  end

  assign gen_en    = busy_q && (!ov_q || out_ready_i);
  assign last_vert = (vert_q == 2'd3) && ((rem_q & ~low) == '0);
  assign load      = q_valid_i && (!busy_q || (gen_en && last_vert));
  assign q_pop_o   = load;

  // Occlusion from the two side neighbors and the diagonal of this corner.
  assign opa  = !cur_q.clear[nb_index(face, vert_q, 1'b1, 1'b0)];
  assign opb  = !cur_q.clear[nb_index(face, vert_q, 1'b0, 1'b1)];
  assign opc  = !cur_q.clear[nb_index(face, vert_q, 1'b1, 1'b1)];
  assign ao   = (opa && opb) ? 2'd0
              : AO_MAX - ({1'b0, opa} + {1'b0, opb} + {1'b0, opc});
  assign cofs = corner_ofs(face, vert_q);
  assign px   = {1'b0, cur_q.x} + {5'd0, cofs[0]};
  assign py   = {1'b0, cur_q.y} + {5'd0, cofs[1]};
  assign pz   = {1'b0, cur_q.z} + {5'd0, cofs[2]};
  assign word = 32'(px) | (32'(py) << POS_Y_SHIFT) | (32'(pz) << POS_Z_SHIFT)
              | (32'(vert_q) << VERT_SHIFT) | (32'(ao) << AO_SHIFT)
              | (32'(tex) << TEX_SHIFT);

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    vert_d = vert_q;
    quad_d = quad_q;
    priority if (load) begin
      busy_d = 1'b1;
      rem_d  = q_head_i.faces;
      vert_d = 2'd0;
      quad_d = q_head_i.base;
    end else if (gen_en && last_vert) begin
      busy_d = 1'b0;
    end else if (gen_en) begin
      vert_d = vert_q + 2'd1;
      if (vert_q == 2'd3) begin
        rem_d  = rem_q & ~low;
        quad_d = quad_q + 1'b1;
      end
    end
    ov_d = gen_en ? 1'b1 : (out_ready_i ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rem_q  <= '0;
      vert_q <= '0;
      quad_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      rem_q  <= rem_d;
      vert_q <= vert_d;
      quad_q <= quad_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_head_i;
    end
    if (gen_en) begin
      word_q <= word;
      qidx_q <= quad_q;
      last_q <= last_vert;
    end
  end

  assign out_valid_o   = ov_q;
  assign vertex_word_o = word_q;
  assign quad_index_o  = qidx_q;
  assign last_o        = last_q;

  `VFM_ASSERT(a_load_busy, load |=> busy_q, "voxel load did not start work")
  `VFM_ASSERT_NEVER(a_busy_faces, busy_q && (rem_q == '0), "busy with no faces left")
  `VFM_ASSERT(a_gen_keeps, gen_en && !last_vert |=> busy_q, "work ended before last vertex")
  `VFM_ASSERT(a_gen_out, gen_en |=> ov_q, "generated vertex not presented")

endmodule

FILE: rtl/core/voxel_face_mesher_with_ao.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// voxel_face_mesher_with_ao
// Voxel face culling mesher with per-vertex ambient occlusion.
// ------------------------------------------------------------------------
// Usage: one voxel is transferred per input handshake (in_valid_i /
// in_ready_o) with its coordinates, solid flag, 27-bit transparency mask of
// the 3x3x3 neighborhood and six face texture ids. Each visible face of a
// solid voxel inside the chunk yields four vertex words on the output channel
// (out_valid_o / out_ready_i), with the quad number and a last flag on the
// final word of the voxel.
// The first word of a voxel passes through the queue, the back part's voxel
// register and its output register before it becomes valid.
// Throughput: one word per cycle while the receiver is ready and voxels are
// queued. A voxel yields four words per visible face, up to 24; air or fully
// hidden voxels never reach the back part, since the front drops them. The
// word rate is set by the vertex generator in the back part.
// Reset clears the quad counter, the queue and the output valid flag.
// When the receiver stalls the output word holds, the back part waits, and
// the four-entry queue fills before in_ready_o drops.
// ------------------------------------------------------------------------
module voxel_face_mesher_with_ao import vfm_pkg::*; #(
  parameter int unsigned CHUNK_SIZE = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       chunk_start_i,
  input  logic [COORD_W-1:0]         block_x_i,
  input  logic [COORD_W-1:0]         block_y_i,
  input  logic [COORD_W-1:0]         block_z_i,
  input  logic                       block_solid_i,
  input  logic [MASK_W-1:0]          neighbour_clear_i,
  input  logic [NUM_FACES*TEX_W-1:0] face_textures_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [31:0]                vertex_word_o,
  output logic [QUAD_W-1:0]          quad_index_o,
  output logic                       last_o
);

  logic       q_push;
  logic       q_ready;
  vfm_entry_t q_entry;
  logic       q_valid;
  logic       q_pop;
  vfm_entry_t q_head;

  vfm_front #(
    .CHUNK_SIZE(CHUNK_SIZE)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .chunk_start_i     (chunk_start_i),
    .block_x_i         (block_x_i),
    .block_y_i         (block_y_i),
    .block_z_i         (block_z_i),
    .block_solid_i     (block_solid_i),
    .neighbour_clear_i (neighbour_clear_i),
    .face_textures_i   (face_textures_i),
    .q_ready_i         (q_ready),
    .q_push_o          (q_push),
    .q_entry_o         (q_entry)
  );

  vfm_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_entry),
    .ready_o      (q_ready),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .head_o       (q_head)
  );

  vfm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .vertex_word_o (vertex_word_o),
    .quad_index_o  (quad_index_o),
    .last_o        (last_o)
  );

endmodule
